// ===== rtl/sogi_pll_pkg.sv =====
// ----------------------------------------------------------------------------
// SOGI PLL package
// Shared constants and helper functions of the single-phase SOGI PLL.
// ----------------------------------------------------------------------------
package sogi_pll_pkg;

  localparam logic signed [63:0] ONE_TURN     = 64'sd1073741824;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam int                 CORDIC_STEPS = 30;

  // Arctangent of 2^-i in Q2.30 quarter turns (quarter turn scaled to 2^30).
  function automatic logic signed [32:0] atan_turns(input logic [4:0] i);
    logic signed [32:0] r;
    begin
      unique case (i)
        5'd0:  r = 33'sd536870912;
        5'd1:  r = 33'sd316933406;
        5'd2:  r = 33'sd167458907;
        5'd3:  r = 33'sd85004756;
        5'd4:  r = 33'sd42667331;
        5'd5:  r = 33'sd21354465;
        5'd6:  r = 33'sd10679838;
        5'd7:  r = 33'sd5340245;
        5'd8:  r = 33'sd2670163;
        5'd9:  r = 33'sd1335087;
        5'd10: r = 33'sd667544;
        5'd11: r = 33'sd333772;
        5'd12: r = 33'sd166886;
        5'd13: r = 33'sd83443;
        5'd14: r = 33'sd41722;
        5'd15: r = 33'sd20861;
        5'd16: r = 33'sd10430;
        5'd17: r = 33'sd5215;
        5'd18: r = 33'sd2608;
        5'd19: r = 33'sd1304;
        5'd20: r = 33'sd652;
        5'd21: r = 33'sd326;
        5'd22: r = 33'sd163;
        5'd23: r = 33'sd81;
        5'd24: r = 33'sd41;
        5'd25: r = 33'sd20;
        5'd26: r = 33'sd10;
        5'd27: r = 33'sd5;
        5'd28: r = 33'sd3;
        5'd29: r = 33'sd1;
        default: r = 33'sd0;
      endcase
      return r;
    end
  endfunction

  // Saturate a 64-bit signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
        r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
        r = 32'sh8000_0000;
      end else begin
        r = v[31:0];
      end
      return r;
    end
  endfunction

endpackage

// ===== rtl/sogi_quadrature_pll.sv =====
// ----------------------------------------------------------------------------
// SOGI quadrature PLL
// Single-phase grid PLL: SOGI filter, Park rotation, PI loop, phase accumulator
// and CORDIC sine/cosine, all on one shared 33x33 multiplier and one CORDIC stage.
// ----------------------------------------------------------------------------
// Sequence: 13 products, each a multiply state and an add state, the frequency
// sum state, 30 CORDIC iterations and the output state, then out_valid. A new
// sample is accepted only in the idle state, so in_stall holds the input until
// the previous sample is through; a full output register holding a beat can
// hold the sequence in the output state.
// Reset (rst_n low, synchronous) clears all filter, loop and phase state and
// loads the register defaults (50 Hz nominal frequency, zero coefficients).
module sogi_quadrature_pll
  import sogi_pll_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TRIG_WIDTH   = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_grid_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_freq_out,
  output logic        [30:0]             out_phase_out,
  output logic signed [31:0]             out_amplitude_out,
  output logic signed [31:0]             out_phase_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic        [2:0]              cfg_index,
  input  logic        [31:0]             cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_FO   = 3'd3;
  localparam logic [2:0] ST_CORD = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [2:0] REG_NOMINAL = 3'd0;
  localparam logic [2:0] REG_PERIOD  = 3'd1;
  localparam logic [2:0] REG_BP      = 3'd2;
  localparam logic [2:0] REG_FB1     = 3'd3;
  localparam logic [2:0] REG_FB2     = 3'd4;
  localparam logic [2:0] REG_LP      = 3'd5;
  localparam logic [2:0] REG_KNOW    = 3'd6;
  localparam logic [2:0] REG_KPREV   = 3'd7;

  localparam logic [3:0] OP_BP    = 4'd0;
  localparam logic [3:0] OP_IFB1  = 4'd1;
  localparam logic [3:0] OP_IFB2  = 4'd2;
  localparam logic [3:0] OP_LP    = 4'd3;
  localparam logic [3:0] OP_QFB1  = 4'd4;
  localparam logic [3:0] OP_QFB2  = 4'd5;
  localparam logic [3:0] OP_ERR0  = 4'd6;
  localparam logic [3:0] OP_ERR1  = 4'd7;
  localparam logic [3:0] OP_AMP0  = 4'd8;
  localparam logic [3:0] OP_AMP1  = 4'd9;
  localparam logic [3:0] OP_LF0   = 4'd10;
  localparam logic [3:0] OP_LF1   = 4'd11;
  localparam logic [3:0] OP_PHASE = 4'd12;

  localparam int TRIG_SHIFT = 31 - TRIG_WIDTH;
  localparam logic signed [33:0] TRIG_LIM = (34'sd1 <<< (TRIG_WIDTH - 1)) - 34'sd1;
  localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);

  // Configuration registers
  logic        [25:0] nominal_r;
  logic        [31:0] period_r;
  logic signed [31:0] bp_r, fb1_r, fb2_r, lp_r, know_r, kprev_r;

  // Loop state
  logic signed [SAMPLE_WIDTH-1:0] u0_r, u1_r, u2_r;
  logic signed [31:0] ih0_r, ih1_r, qh0_r, qh1_r, prev_err_r, loop_out_r;
  logic        [30:0] phase_r;
  logic signed [TRIG_WIDTH-1:0] sin_r, cos_r;

  // Working registers
  logic [2:0]         state_r;
  logic [3:0]         op_r;
  logic signed [65:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] ip_r, qd_r, err_r, amp_r, lf_r, fo_r;
  logic        [30:0] t_r;
  logic        [1:0]  quad_r;
  logic        [4:0]  iter_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic               out_valid_r;

  // Multiplier operand selection
  logic signed [32:0] mul_a, mul_b;
  logic signed [SAMPLE_WIDTH:0]   u_diff;
  logic signed [SAMPLE_WIDTH+1:0] u_sum;

  assign u_diff = $signed({u0_r[SAMPLE_WIDTH-1], u0_r})
                  - $signed({u2_r[SAMPLE_WIDTH-1], u2_r});
  assign u_sum  = (SAMPLE_WIDTH+2)'($signed(u0_r)) + ((SAMPLE_WIDTH+2)'($signed(u1_r)) <<< 1)
                  + (SAMPLE_WIDTH+2)'($signed(u2_r));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_r)
      OP_BP:    begin mul_a = 33'(bp_r);  mul_b = 33'(u_diff); end
      OP_IFB1:  begin mul_a = 33'(fb1_r); mul_b = 33'(ih0_r);  end
      OP_IFB2:  begin mul_a = 33'(fb2_r); mul_b = 33'(ih1_r);  end
      OP_LP:    begin mul_a = 33'(lp_r);  mul_b = 33'(u_sum);  end
      OP_QFB1:  begin mul_a = 33'(fb1_r); mul_b = 33'(qh0_r);  end
      OP_QFB2:  begin mul_a = 33'(fb2_r); mul_b = 33'(qh1_r);  end
      OP_ERR0:  begin mul_a = 33'(cos_r); mul_b = 33'(ip_r);   end
      OP_ERR1:  begin mul_a = 33'(sin_r); mul_b = 33'(qd_r);   end
      OP_AMP0:  begin mul_a = 33'(cos_r); mul_b = 33'(qd_r);   end
      OP_AMP1:  begin mul_a = 33'(sin_r); mul_b = 33'(ip_r);   end
      OP_LF0:   begin mul_a = 33'(know_r);  mul_b = 33'(err_r);      end
      OP_LF1:   begin mul_a = 33'(kprev_r); mul_b = 33'(prev_err_r); end
      OP_PHASE: begin mul_a = 33'(fo_r);  mul_b = $signed({1'b0, period_r}); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Product scaling and accumulation
  logic [4:0]         sh_amt;
  logic               grp_start, grp_end, do_sub;
  logic signed [63:0] acc_base, term, acc_sum;
  logic signed [65:0] prod_sh;

  always_comb begin
    sh_amt    = 5'd30;
    grp_start = 1'b0;
    grp_end   = 1'b0;
    do_sub    = 1'b0;
    acc_base  = acc_r;
    case (op_r)
      OP_BP, OP_LP: begin
        sh_amt = 5'(SAMPLE_WIDTH + 1);
        grp_start = 1'b1;
      end
      OP_IFB2, OP_QFB2: grp_end = 1'b1;
      OP_ERR0, OP_AMP0: begin
        sh_amt = 5'(TRIG_WIDTH - 1);
        grp_start = 1'b1;
      end
      OP_ERR1: begin
        sh_amt = 5'(TRIG_WIDTH - 1);
        grp_end = 1'b1;
      end
      OP_AMP1: begin
        sh_amt = 5'(TRIG_WIDTH - 1);
        grp_end = 1'b1;
        do_sub = 1'b1;
      end
      OP_LF0: begin
        sh_amt = 5'd28;
        grp_start = 1'b1;
        acc_base = 64'(loop_out_r);
      end
      OP_LF1: begin
        sh_amt = 5'd28;
        grp_end = 1'b1;
      end
      OP_PHASE: begin
        sh_amt = 5'd18;
        grp_start = 1'b1;
        grp_end = 1'b1;
        acc_base = $signed({33'b0, phase_r});
      end
      default: ;
    endcase
    if (grp_start && op_r != OP_LF0 && op_r != OP_PHASE) begin
      acc_base = '0;
    end
    prod_sh = prod_r >>> sh_amt;
    term    = prod_sh[63:0];
    acc_sum = do_sub ? (acc_base - term) : (acc_base + term);
  end

  logic signed [31:0] acc_sat;
  logic signed [63:0] fo_sum;
  logic        [30:0] t_next;

  assign acc_sat = sat32(acc_sum);
  assign fo_sum  = $signed({38'b0, nominal_r}) + 64'(lf_r);
  assign t_next  = (acc_sum > ONE_TURN || acc_sum < 64'sd0) ? 31'd0 : acc_sum[30:0];

  // CORDIC stage
  logic signed [33:0] cdx, cdy;
  logic signed [32:0] catan;
  assign cdx   = cy_r >>> iter_r;
  assign cdy   = cx_r >>> iter_r;
  assign catan = atan_turns(iter_r);

  function automatic logic signed [TRIG_WIDTH-1:0] trig_limit(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = v >>> TRIG_SHIFT;
      if (r > TRIG_LIM) begin
        r = TRIG_LIM;
      end else if (r < -TRIG_LIM) begin
        r = -TRIG_LIM;
      end
      return r[TRIG_WIDTH-1:0];
    end
  endfunction

  logic signed [33:0] c_raw, s_raw;
  always_comb begin
    unique case (quad_r)
      2'd0:    begin c_raw = cx_r;  s_raw = cy_r;  end
      2'd1:    begin c_raw = -cy_r; s_raw = cx_r;  end
      2'd2:    begin c_raw = -cx_r; s_raw = -cy_r; end
      default: begin c_raw = cy_r;  s_raw = -cx_r; end
    endcase
  end

  logic out_free;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_BP;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      nominal_r   <= 26'd3276800;
      period_r    <= 32'd214748;
      bp_r        <= '0;
      fb1_r       <= '0;
      fb2_r       <= '0;
      lp_r        <= '0;
      know_r      <= '0;
      kprev_r     <= '0;
      u1_r        <= '0;
      u2_r        <= '0;
      ih0_r       <= '0;
      ih1_r       <= '0;
      qh0_r       <= '0;
      qh1_r       <= '0;
      prev_err_r  <= '0;
      loop_out_r  <= '0;
      phase_r     <= '0;
      sin_r       <= '0;
      cos_r       <= '0;
    end else begin
      // In the output state a taken beat is replaced by the new one below.
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NOMINAL: nominal_r <= cfg_data[25:0];
          REG_PERIOD:  period_r  <= cfg_data;
          REG_BP:      bp_r      <= cfg_data;
          REG_FB1:     fb1_r     <= cfg_data;
          REG_FB2:     fb2_r     <= cfg_data;
          REG_LP:      lp_r      <= cfg_data;
          REG_KNOW:    know_r    <= cfg_data;
          REG_KPREV:   kprev_r   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            u0_r    <= in_grid_sample;
            op_r    <= OP_BP;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          acc_r <= acc_sum;
          if (grp_end) begin
            case (op_r)
              OP_IFB2: ip_r  <= acc_sat;
              OP_QFB2: qd_r  <= acc_sat;
              OP_ERR1: err_r <= acc_sat;
              OP_AMP1: amp_r <= acc_sat;
              OP_LF1:  lf_r  <= acc_sat;
              default: ;
            endcase
          end
          if (op_r == OP_LF1) begin
            state_r <= ST_FO;
          end else if (op_r == OP_PHASE) begin
            // Commit the loop state and start the sine/cosine of the new phase.
            t_r        <= t_next;
            phase_r    <= t_next;
            quad_r     <= t_next[29:28];
            cx_r       <= CORDIC_START;
            cy_r       <= '0;
            cz_r       <= $signed({3'b0, t_next[27:0], 2'b00});
            iter_r     <= '0;
            u1_r       <= u0_r;
            u2_r       <= u1_r;
            ih0_r      <= ip_r;
            ih1_r      <= ih0_r;
            qh0_r      <= qd_r;
            qh1_r      <= qh0_r;
            prev_err_r <= err_r;
            loop_out_r <= lf_r;
            state_r    <= ST_CORD;
          end else begin
            op_r    <= op_r + 4'd1;
            state_r <= ST_MUL;
          end
        end
        ST_FO: begin
          fo_r    <= sat32(fo_sum);
          op_r    <= OP_PHASE;
          state_r <= ST_MUL;
        end
        ST_CORD: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            cz_r <= cz_r - catan;
          end else begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            cz_r <= cz_r + catan;
          end
          if (iter_r == LAST_ITER) begin
            state_r <= ST_DONE;
          end else begin
            iter_r <= iter_r + 5'd1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            cos_r             <= trig_limit(c_raw);
            sin_r             <= trig_limit(s_raw);
            out_valid_r       <= 1'b1;
            out_freq_out      <= fo_r;
            out_phase_out     <= t_r;
            out_amplitude_out <= amp_r;
            out_phase_error   <= err_r;
            state_r           <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The phase accumulator never leaves the range from zero to one turn.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 31'd1073741824)
    else $error("phase accumulator beyond one turn");

  // An accepted sample starts the first product of the in-phase filter.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_MUL && op_r == OP_BP)
    else $error("accepted sample did not start the sequence");

  // The CORDIC iteration count stays within the rotation table.
  a_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CORD |-> iter_r <= LAST_ITER)
    else $error("CORDIC iteration beyond table");

  // A result beat is only produced after the CORDIC pass.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result beat without finished sequence");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// SOGI quadrature PLL testbench
// Feeds grid samples through the valid/stall channels under several register
// settings and idle patterns. Every result beat is checked, field by field,
// against a bit-exact model of the filter, Park rotation, PI loop, phase
// accumulator and CORDIC kept inside this module, or for a typed row against its given result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sogi_pll_pkg::*;

  localparam int SW          = 16;
  localparam int TW          = 18;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 70;
  localparam longint CORDIC_START_VAL = 64'sd652032874;

  typedef enum logic [2:0] {
    REG_NOMINAL_FREQ, REG_SAMPLE_PERIOD, REG_BANDPASS_GAIN, REG_FEEDBACK_ONE,
    REG_FEEDBACK_TWO, REG_LOWPASS_GAIN, REG_LOOP_GAIN_NOW, REG_LOOP_GAIN_PREV
  } reg_index_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef enum int {
    SET_RESET, SET_TYPICAL, SET_WRAP, SET_MAX, SET_MIN, SET_BACKWARD, SET_RANDOM,
    SET_FROZEN, SET_KEEP
  } cfg_set_e;

  typedef struct {
    logic signed [31:0] freq;
    logic [30:0]        phase;
    logic signed [31:0] amplitude;
    logic signed [31:0] error;
  } pll_result_t;

  typedef struct {
    cfg_set_e           cfg;
    logic signed [15:0] sample;
    bit                 typed;
    pll_result_t        result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_grid_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_freq_out;
  logic [30:0] out_phase_out;
  logic signed [31:0] out_amplitude_out;
  logic signed [31:0] out_phase_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sogi_quadrature_pll #(.SAMPLE_WIDTH(SW), .TRIG_WIDTH(TW)) dut (.*);

  always #5 clk = ~clk;

  // Model copy of the registers and of the loop state.
  logic [25:0] nom_freq;
  logic [31:0] samp_period;
  logic signed [31:0] gain_bp, gain_fb1, gain_fb2, gain_lp, gain_now, gain_prev;
  longint u_hist1, u_hist2, ip_hist1, ip_hist2, qd_hist1, qd_hist2;
  longint err_last, loop_acc, turns_acc, sin_val, cos_val;

  longint arctan_tbl[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  logic [31:0] cfg_sets[SET_KEEP][8];

  pll_result_t pending_results[$];
  int errors = 0;
  int samples_sent = 0;
  int beats_checked = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int wave_val = 0;
  int wave_step = 700;
  int wave_peak = 20000;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint trig_clamp(longint v);
    longint r;
    longint lim;
    lim = (64'sd1 <<< (TW - 1)) - 1;
    r = v >>> (31 - TW);
    if (r > lim) return lim;
    if (r < -lim) return -lim;
    return r;
  endfunction

  task automatic compute_trig(longint turns);
    logic [31:0] a;
    longint x, y, z, dx, dy, c, s;
    a = 32'(turns << 2);
    x = CORDIC_START_VAL;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_tbl[i];
      end else begin
        x += dx; y -= dy; z += arctan_tbl[i];
      end
    end
    case (a[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cos_val = trig_clamp(c);
    sin_val = trig_clamp(s);
  endtask

  task automatic track_sample(input logic signed [15:0] smp, output pll_result_t r);
    longint u0, ip, qd, err, amp, lf, fo, t;
    u0 = smp;
    ip = clamp32(((longint'(gain_bp) * (u0 - u_hist2)) >>> (SW + 1))
                 + ((longint'(gain_fb1) * ip_hist1) >>> 30)
                 + ((longint'(gain_fb2) * ip_hist2) >>> 30));
    qd = clamp32(((longint'(gain_lp) * (u0 + 2 * u_hist1 + u_hist2)) >>> (SW + 1))
                 + ((longint'(gain_fb1) * qd_hist1) >>> 30)
                 + ((longint'(gain_fb2) * qd_hist2) >>> 30));
    u_hist2 = u_hist1;   u_hist1 = u0;
    ip_hist2 = ip_hist1; ip_hist1 = ip;
    qd_hist2 = qd_hist1; qd_hist1 = qd;
    err = clamp32(((cos_val * ip) >>> (TW - 1)) + ((sin_val * qd) >>> (TW - 1)));
    amp = clamp32(((cos_val * qd) >>> (TW - 1)) - ((sin_val * ip) >>> (TW - 1)));
    lf = clamp32(loop_acc + ((longint'(gain_now) * err) >>> 28)
                 + ((longint'(gain_prev) * err_last) >>> 28));
    err_last = err;
    loop_acc = lf;
    fo = clamp32(longint'(nom_freq) + lf);
    t = turns_acc + ((fo * longint'(samp_period)) >>> 18);
    // Past one turn or below zero, the phase restarts at zero.
    if (t > ONE_TURN || t < 0) t = 0;
    turns_acc = t;
    compute_trig(t);
    r.freq = fo[31:0];
    r.phase = t[30:0];
    r.amplitude = amp[31:0];
    r.error = err[31:0];
  endtask

  task automatic write_reg(reg_index_e idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NOMINAL_FREQ:  nom_freq = val[25:0];
      REG_SAMPLE_PERIOD: samp_period = val;
      REG_BANDPASS_GAIN: gain_bp = val;
      REG_FEEDBACK_ONE:  gain_fb1 = val;
      REG_FEEDBACK_TWO:  gain_fb2 = val;
      REG_LOWPASS_GAIN:  gain_lp = val;
      REG_LOOP_GAIN_NOW: gain_now = val;
      default:           gain_prev = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic load_set(cfg_set_e set);
    drain();
    if (set == SET_RANDOM) begin
      cfg_sets[SET_RANDOM][0] = $urandom_range(32'h3FF_FFFF);
      for (int i = 1; i < 8; i++) cfg_sets[SET_RANDOM][i] = $urandom;
    end
    for (int i = 0; i < 8; i++) write_reg(reg_index_e'(i), cfg_sets[set][i]);
  endtask

  // Entered and left just after a falling edge.
  task automatic send_sample(logic signed [15:0] smp, bit typed, pll_result_t typed_res);
    pll_result_t r;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_grid_sample <= smp;
    do @(posedge clk); while (in_stall);
    track_sample(smp, r);
    pending_results.push_back(typed ? typed_res : r);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic set_idle(idle_mode_e m);
    send_pct = (m == IDLE_SENDER) ? 53 : (m == IDLE_BOTH) ? 28 : 0;
    stall_pct = (m == IDLE_RECEIVER) ? 53 : (m == IDLE_BOTH) ? 28 : 0;
  endtask

  // Mostly a bouncing ramp of random slope and height, with some raw noise.
  function automatic logic signed [15:0] next_wave();
    if ($urandom_range(99) < 15) return 16'($urandom);
    wave_val += wave_step;
    if (wave_val > wave_peak || wave_val < -wave_peak) begin
      wave_step = -wave_step;
      wave_val += 2 * wave_step;
    end
    return 16'(wave_val);
  endfunction

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack = hold_req;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    pll_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (out_freq_out !== e.freq) begin
          $error("freq_out: expected %0d, got %0d", e.freq, out_freq_out);
          errors++;
        end
        if (out_phase_out !== e.phase) begin
          $error("phase_out: expected %0d, got %0d", e.phase, out_phase_out);
          errors++;
        end
        if (out_amplitude_out !== e.amplitude) begin
          $error("amplitude_out: expected %0d, got %0d", e.amplitude, out_amplitude_out);
          errors++;
        end
        if (out_phase_error !== e.error) begin
          $error("phase_error: expected %0d, got %0d", e.error, out_phase_error);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("sogi_quadrature_pll verification failed");
        $finish;
      end
    end
  end

  directed_row_t dir_rows[$];
  cfg_set_e phase_sets[7] = '{SET_TYPICAL, SET_WRAP, SET_MAX, SET_MIN, SET_BACKWARD,
                             SET_RANDOM, SET_TYPICAL};
  idle_mode_e phase_idle[7] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                               IDLE_RECEIVER, IDLE_NONE, IDLE_BOTH};

  initial begin
    pll_result_t none;
    directed_row_t row;
    logic signed [15:0] dir_samples[$];
    none = '{default: '0};
    cfg_sets[SET_RESET]    = '{32'd3276800, 32'd214748, 0, 0, 0, 0, 0, 0};
    cfg_sets[SET_TYPICAL]  = '{32'd3276800, 32'd429497, 32'h0200_0000, 32'h7E00_0000,
                               32'hC200_0000, 32'h0010_0000, 32'h0020_0000, 32'hFFE1_0000};
    cfg_sets[SET_WRAP]     = cfg_sets[SET_TYPICAL];
    cfg_sets[SET_WRAP][1]  = 32'hFFFF_FFFF;
    cfg_sets[SET_FROZEN]   = cfg_sets[SET_TYPICAL];
    cfg_sets[SET_FROZEN][1] = 32'd0;
    cfg_sets[SET_MAX]      = '{32'h3FF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    cfg_sets[SET_MIN]      = '{32'd0, 32'd1, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    cfg_sets[SET_BACKWARD] = cfg_sets[SET_TYPICAL];
    cfg_sets[SET_BACKWARD][0] = 32'd0;
    cfg_sets[SET_BACKWARD][6] = 32'h8000_0000;
    cfg_sets[SET_BACKWARD][7] = 32'h8000_0000;
    for (int i = 0; i < 8; i++) cfg_sets[SET_RANDOM][i] = '0;

    nom_freq = 26'd3276800; samp_period = 32'd214748;
    gain_bp = 0; gain_fb1 = 0; gain_fb2 = 0; gain_lp = 0; gain_now = 0; gain_prev = 0;
    u_hist1 = 0; u_hist2 = 0; ip_hist1 = 0; ip_hist2 = 0; qd_hist1 = 0; qd_hist2 = 0;
    err_last = 0; loop_acc = 0; turns_acc = 0; sin_val = 0; cos_val = 0;

    // First sample after reset: sin and cos are zero, so the Park outputs are zero.
    dir_rows.push_back('{SET_KEEP, 16'sd0, 1'b1, '{32'sd3276800, 31'd2684350, 0, 0}});
    dir_rows.push_back('{SET_KEEP, 16'sh7FFF, 1'b0, none});
    dir_rows.push_back('{SET_TYPICAL, 16'sh7FFF, 1'b0, none});
    dir_samples = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sh5555,
                    16'shAAAA, 16'sd16384, -16'sd16384};
    foreach (dir_samples[i]) dir_rows.push_back('{SET_KEEP, dir_samples[i], 1'b0, none});
    // Zero sample period holds the phase; a huge one pushes it past a turn.
    dir_rows.push_back('{SET_FROZEN, 16'sd12000, 1'b0, none});
    dir_rows.push_back('{SET_KEEP, -16'sd12000, 1'b0, none});
    dir_rows.push_back('{SET_WRAP, 16'sd5000, 1'b0, none});
    dir_rows.push_back('{SET_KEEP, 16'sd9000, 1'b0, none});
    dir_rows.push_back('{SET_KEEP, -16'sd3000, 1'b0, none});
    // Zero nominal frequency with a strongly negative loop drives the phase backward.
    dir_rows.push_back('{SET_BACKWARD, 16'sh7FFF, 1'b0, none});
    dir_rows.push_back('{SET_KEEP, 16'sh7FFF, 1'b0, none});
    dir_rows.push_back('{SET_KEEP, 16'sh8000, 1'b0, none});
    dir_rows.push_back('{SET_KEEP, 16'sh8000, 1'b0, none});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg != SET_KEEP) load_set(row.cfg);
      send_sample(row.sample, row.typed, row.result);
    end

    for (int p = 0; p < 7; p++) begin
      load_set(phase_sets[p]);
      set_idle(phase_idle[p]);
      wave_val = 0;
      wave_peak = $urandom_range(32000, 500);
      wave_step = $urandom_range(wave_peak / 4 + 1, 20);
      for (int n = 0; n < 84; n++) begin
        if (p == 4 && n == 10) begin
          send_pct = 0;
          hold_req++;
        end
        if (p == 4 && n == 50) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        send_sample(next_wave(), 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d grid samples, checked %0d result beats, across 8 register settings",
             samples_sent, beats_checked);
    $display("including wraparound, backward phase, frozen phase and saturating extremes.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("sogi_quadrature_pll verification clean");
    end else begin
      $display("sogi_quadrature_pll verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sogi_pll_pkg.sv
rtl/sogi_quadrature_pll.sv
test/testbench.sv
